/* design/air_sensor_frame_trimmed_mean_unit_macros.svh */
// assertion macros shared by the frame averaging unit
`ifndef AIR_SENSOR_FRAME_TRIMMED_MEAN_UNIT_MACROS_SVH
`define AIR_SENSOR_FRAME_TRIMMED_MEAN_UNIT_MACROS_SVH

// implication checked out of reset
`define ASFM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asfm check failed");

// next-cycle implication, also checked while in reset
`define ASFM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("asfm check failed");

`endif

/* design/asfm_pkg.sv */
// types and constants of the air sensor frame averaging unit
package asfm_pkg;

  localparam int CHANNELS   = 7;
  localparam int DATA_BYTES = 14;

  localparam logic [7:0] HDR_A    = 8'h3c;
  localparam logic [7:0] HDR_B    = 8'h02;
  localparam logic [7:0] SUM_SEED = 8'd62;

  localparam logic [1:0] ST_CSUM_FAIL = 2'd0;
  localparam logic [1:0] ST_WARMUP    = 2'd1;
  localparam logic [1:0] ST_FILLING   = 2'd2;
  localparam logic [1:0] ST_UPDATED   = 2'd3;

  typedef logic [15:0] sample_t;

  // one parsed frame; kind is a fail code or ST_FILLING for a frame to store
  typedef struct packed {
    logic [1:0]                 kind;
    logic [CHANNELS-1:0][15:0] vals;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* design/asfm_front.sv */
// byte parser: header hunt, data capture, checksum and warm-up classification
module asfm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  output logic                   push,
  output asfm_pkg::frame_t       frame
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  logic [1:0] phase_r;
  logic [3:0] idx_r;
  logic [7:0] csum_r;
  logic [7:0] bytes_r [asfm_pkg::DATA_BYTES];
  logic       last_byte;
  logic       warmup;

  assign last_byte = (idx_r == 4'(asfm_pkg::DATA_BYTES));
  assign push      = accept && (phase_r == PH_COLLECT) && last_byte;

  always_comb begin
    for (int c = 0; c < 5; c++) begin
      frame.vals[c] = {bytes_r[2*c], bytes_r[2*c+1]};
    end
    // byte times ten as two shifts
    frame.vals[5] = {5'd0, bytes_r[10], 3'd0} + {7'd0, bytes_r[10], 1'b0}
                  + {8'd0, bytes_r[11]};
    frame.vals[6] = {5'd0, bytes_r[12], 3'd0} + {7'd0, bytes_r[12], 1'b0}
                  + {8'd0, bytes_r[13]};
    warmup = (frame.vals[0] == 16'd0) && (frame.vals[1] == 16'd0)
          && (frame.vals[2] == 16'd0);
    if (warmup) begin
      frame.kind = asfm_pkg::ST_WARMUP;
    end else if (csum_r != rx_byte) begin
      frame.kind = asfm_pkg::ST_CSUM_FAIL;
    end else begin
      frame.kind = asfm_pkg::ST_FILLING;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_COLLECT && !last_byte) begin
      bytes_r[idx_r] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= 4'd0;
      csum_r  <= 8'd0;
    end else if (accept) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == asfm_pkg::HDR_A) phase_r <= PH_HEADER;
        end
        PH_HEADER: begin
          if (rx_byte == asfm_pkg::HDR_B) begin
            phase_r <= PH_COLLECT;
            idx_r   <= 4'd0;
            csum_r  <= asfm_pkg::SUM_SEED;
          end else begin
            phase_r <= PH_HUNT;
          end
        end
        PH_COLLECT: begin
          if (!last_byte) begin
            csum_r <= csum_r + rx_byte;
            idx_r  <= idx_r + 4'd1;
          end else begin
            phase_r <= PH_HUNT;
            idx_r   <= 4'd0;
          end
        end
        default: begin
          phase_r <= PH_HUNT;
        end
      endcase
    end
  end

endmodule

/* design/asfm_queue.sv */
// two-entry frame queue between parser and averaging engine
module asfm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  asfm_pkg::frame_t    push_data,
  input  logic                pop,
  output asfm_pkg::frame_t    head,
  output asfm_pkg::q_stat_t   stat
);

  asfm_pkg::frame_t mem_r [2];
  logic             wr_r;
  logic             rd_r;
  logic [1:0]       cnt_r;

  assign head       = mem_r[rd_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* design/asfm_back.sv */
// averaging engine: history shift, lane-parallel trimmed sum and reciprocal divide
module asfm_back #(
  parameter int HISTORY_DEPTH = 7
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  asfm_pkg::frame_t                             head,
  input  asfm_pkg::q_stat_t                            q_stat,
  output logic                                         pop,
  input  logic                                         out_stall,
  output logic                                         out_valid,
  output logic [1:0]                                   out_status,
  output logic [asfm_pkg::CHANNELS-1:0][15:0]          out_avg
);

  localparam int CH      = asfm_pkg::CHANNELS;
  localparam int SUM_W   = 16 + $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH);
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int DIVISOR = HISTORY_DEPTH - 2;
  // floor(n / DIVISOR) equals (n * RECIP) >> DIV_SH for every n below 2**SUM_W
  localparam int DIV_SH  = SUM_W + $clog2(DIVISOR);
  localparam int MUL_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << DIV_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_ACC  = 3'd1;
  localparam logic [2:0] B_TRIM = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  logic [2:0]        state_r;
  logic [CNT_W-1:0]  step_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [1:0]        status_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_free;
  logic              out_load;

  logic [15:0]       hist_r [CH][HISTORY_DEPTH];
  logic [SUM_W-1:0]  sum_r  [CH];
  logic [15:0]       hi_r   [CH];
  logic [15:0]       lo_r   [CH];
  logic [SUM_W-1:0]  num_r  [CH];
  logic [15:0]       avg_r  [CH];
  logic [PROD_W-1:0] prod   [CH];

  assign pop        = (state_r == B_IDLE) && !q_stat.empty;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_load   = (state_r == B_DONE) && out_free;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign fill_nxt   = (fill_r < FILL_W'(HISTORY_DEPTH)) ? fill_r + 1'b1 : fill_r;

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      out_avg[c] = avg_r[c];
      prod[c]    = PROD_W'(num_r[c]) * PROD_W'(RECIP);
    end
  end

  // history: shift in on store, rotate once per cycle while accumulating
  always_ff @(posedge clk) begin
    if ((pop && head.kind == asfm_pkg::ST_FILLING) || state_r == B_ACC) begin
      for (int c = 0; c < CH; c++) begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
          hist_r[c][i] <= hist_r[c][i-1];
        end
        hist_r[c][0] <= (state_r == B_ACC) ? hist_r[c][HISTORY_DEPTH-1] : head.vals[c];
      end
    end
  end

  // lane datapath
  always_ff @(posedge clk) begin
    for (int c = 0; c < CH; c++) begin
      case (state_r)
        B_ACC: begin
          if (step_r == '0) begin
            sum_r[c] <= SUM_W'(hist_r[c][HISTORY_DEPTH-1]);
            hi_r[c]  <= hist_r[c][HISTORY_DEPTH-1];
            lo_r[c]  <= hist_r[c][HISTORY_DEPTH-1];
          end else begin
            sum_r[c] <= sum_r[c] + SUM_W'(hist_r[c][HISTORY_DEPTH-1]);
            if (hist_r[c][HISTORY_DEPTH-1] > hi_r[c]) hi_r[c] <= hist_r[c][HISTORY_DEPTH-1];
            if (hist_r[c][HISTORY_DEPTH-1] < lo_r[c]) lo_r[c] <= hist_r[c][HISTORY_DEPTH-1];
          end
        end
        B_TRIM: begin
          num_r[c] <= sum_r[c] - SUM_W'(hi_r[c]) - SUM_W'(lo_r[c]);
        end
        B_DIV: begin
          // quotient always fits 16 bits since the trimmed sum has DIVISOR terms
          num_r[c] <= SUM_W'(prod[c][DIV_SH +: 16]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      step_r       <= '0;
      fill_r       <= '0;
      status_r     <= asfm_pkg::ST_CSUM_FAIL;
      out_valid_r  <= 1'b0;
      out_status_r <= asfm_pkg::ST_CSUM_FAIL;
      for (int c = 0; c < CH; c++) avg_r[c] <= 16'd0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (pop) begin
            step_r <= '0;
            if (head.kind == asfm_pkg::ST_FILLING) begin
              fill_r <= fill_nxt;
              if (fill_nxt == FILL_W'(HISTORY_DEPTH)) begin
                status_r <= asfm_pkg::ST_UPDATED;
                state_r  <= B_ACC;
              end else begin
                status_r <= asfm_pkg::ST_FILLING;
                state_r  <= B_DONE;
              end
            end else begin
              status_r <= head.kind;
              state_r  <= B_DONE;
            end
          end
        end
        B_ACC: begin
          if (step_r == CNT_W'(HISTORY_DEPTH - 1)) begin
            state_r <= B_TRIM;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        B_TRIM: begin
          step_r  <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            if (status_r == asfm_pkg::ST_UPDATED) begin
              for (int c = 0; c < CH; c++) avg_r[c] <= num_r[c][15:0];
            end
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/air_sensor_frame_trimmed_mean_unit.sv */
// air sensor frame parser with trimmed-mean averaging, top level
// throughput: one byte item per cycle; in_stall rises only when both queue slots hold frames
// path: a status 0, 1 or 2 report passes the queue, the engine's pop in idle and the output load
// status 3 adds the history pass, trim and reciprocal divide before the output load
// synchronous active-low reset clears parser, queue, fill count and averages to zero
// sample history is not cleared; the fill count keeps unwritten entries out of the averages
module air_sensor_frame_trimmed_mean_unit #(
  parameter int HISTORY_DEPTH = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_avg_co2,
  output logic [15:0] out_avg_formaldehyde,
  output logic [15:0] out_avg_voc,
  output logic [15:0] out_avg_fine_dust,
  output logic [15:0] out_avg_coarse_dust,
  output logic [11:0] out_avg_temperature,
  output logic [11:0] out_avg_humidity
);

  `include "air_sensor_frame_trimmed_mean_unit_macros.svh"

  logic                                  in_accept;
  logic                                  fr_push;
  asfm_pkg::frame_t                      fr_frame;
  asfm_pkg::frame_t                      q_head;
  asfm_pkg::q_stat_t                     q_stat;
  logic                                  bk_pop;
  logic [asfm_pkg::CHANNELS-1:0][15:0]   avg;

  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;

  asfm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_rx_byte),
    .push    (fr_push),
    .frame   (fr_frame)
  );

  asfm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_push),
    .push_data (fr_frame),
    .pop       (bk_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  asfm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (bk_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_status (out_frame_status),
    .out_avg    (avg)
  );

  assign out_avg_co2          = avg[0];
  assign out_avg_formaldehyde = avg[1];
  assign out_avg_voc          = avg[2];
  assign out_avg_fine_dust    = avg[3];
  assign out_avg_coarse_dust  = avg[4];
  assign out_avg_temperature  = avg[5][11:0];
  assign out_avg_humidity     = avg[6][11:0];

  `ASFM_ASSERT_IMP(a_no_push_full, fr_push, !q_stat.full)
  `ASFM_ASSERT_IMP(a_no_pop_empty, bk_pop, !q_stat.empty)
  `ASFM_ASSERT_NXT(a_reset_out_idle, !rst_n, !out_valid)

endmodule

/* test/tb_air_sensor_frame_trimmed_mean_unit.sv */
// testbench for the air sensor frame averaging unit: byte streams in, frame reports checked
module tb_air_sensor_frame_trimmed_mean_unit;

  localparam int HISTORY_DEPTH = 7;
  localparam int TOTAL_BYTES   = 1450;
  localparam int CALM_TAIL     = 200;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 3000;

  localparam logic [1:0] S_FAIL = asfm_pkg::ST_CSUM_FAIL;
  localparam logic [1:0] S_WARM = asfm_pkg::ST_WARMUP;
  localparam logic [1:0] S_FILL = asfm_pkg::ST_FILLING;
  localparam logic [1:0] S_UPD  = asfm_pkg::ST_UPDATED;

  typedef enum logic [1:0] {HUNT_A, WAIT_B, COLLECT} parse_state_t;

  // one frame report: status plus the seven channel averages
  typedef struct packed {
    logic [1:0]                          status;
    logic [asfm_pkg::CHANNELS-1:0][15:0] avg;
  } frame_report_t;

  // one byte item; the checksum byte of a typed row carries its status
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [1:0] status;
  } rx_item_t;

  // directed frame: lead bytes, data, checksum offset, typed status or predicted
  typedef struct packed {
    logic [2:0]       lead_n;
    logic [0:3][7:0]  lead;
    logic [0:13][7:0] data;
    logic [7:0]       skew;
    logic             typed;
    logic [1:0]       status;
  } frame_row_t;

  localparam int DIR_ROWS = 20;
  localparam frame_row_t DIR_TAB [DIR_ROWS] = '{
    '{3'd0, 32'h0000_0000, 112'h0000_0000_0000_ffff_ffff_ffff_ffff, 8'h00, 1'b1, S_WARM},
    '{3'd2, 32'h3c05_0000, 112'h0000_0000_0000_0000_0000_0000_0000, 8'h5a, 1'b1, S_WARM},
    '{3'd2, 32'h3c3c_0000, 112'hffff_ffff_ffff_ffff_ffff_ffff_ffff, 8'h01, 1'b1, S_FAIL},
    '{3'd1, 32'hff00_0000, 112'h0001_0000_0000_0000_0000_0000_0000, 8'h00, 1'b1, S_FILL},
    '{3'd0, 32'h0000_0000, 112'h0000_0001_0000_0000_0000_0000_0000, 8'h00, 1'b1, S_FILL},
    '{3'd0, 32'h0000_0000, 112'h0000_0000_0001_0000_0000_0000_0000, 8'h00, 1'b1, S_FILL},
    '{3'd4, 32'h3c3c_3c00, 112'hffff_ffff_ffff_ffff_ffff_ffff_ffff, 8'h00, 1'b1, S_FILL},
    '{3'd0, 32'h0000_0000, 112'h1234_5678_9abc_def0_0fed_1909_3200, 8'hff, 1'b1, S_FAIL},
    '{3'd0, 32'h0000_0000, 112'h8000_0000_0000_7fff_0001_0a05_1e00, 8'h00, 1'b1, S_FILL},
    '{3'd0, 32'h0000_0000, 112'h0000_8000_0000_0001_8000_ff00_00ff, 8'h00, 1'b1, S_FILL},
    '{3'd0, 32'h0000_0000, 112'hffff_ffff_ffff_ffff_ffff_ffff_ffff, 8'h00, 1'b0, S_UPD},
    '{3'd0, 32'h0000_0000, 112'h0000_0000_0001_0000_0000_0000_0000, 8'h00, 1'b0, S_UPD},
    '{3'd0, 32'h0000_0000, 112'hffff_0000_ffff_0000_ffff_0000_ffff, 8'h00, 1'b0, S_UPD},
    '{3'd0, 32'h0000_0000, 112'h0000_ffff_0000_ffff_0000_ff00_00ff, 8'h00, 1'b0, S_UPD},
    '{3'd2, 32'h3c05_0000, 112'h0000_0000_0000_1111_2222_3333_4444, 8'h77, 1'b0, S_WARM},
    '{3'd0, 32'h0000_0000, 112'h0102_0304_0506_0708_090a_0b0c_0d0e, 8'h80, 1'b0, S_FAIL},
    '{3'd0, 32'h0000_0000, 112'haaaa_5555_aaaa_5555_aaaa_55aa_55aa, 8'h00, 1'b0, S_UPD},
    '{3'd0, 32'h0000_0000, 112'h5555_aaaa_5555_aaaa_5555_aa55_aa55, 8'h00, 1'b0, S_UPD},
    '{3'd0, 32'h0000_0000, 112'h0000_0000_8000_0000_0000_0000_0000, 8'h00, 1'b0, S_UPD},
    '{3'd2, 32'h3c00_0000, 112'hffff_ffff_ffff_ffff_ffff_ffff_ffff, 8'h00, 1'b0, S_UPD}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        in_typed;
  logic [1:0]  in_status;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_frame_status;
  logic [15:0] out_avg_co2;
  logic [15:0] out_avg_formaldehyde;
  logic [15:0] out_avg_voc;
  logic [15:0] out_avg_fine_dust;
  logic [15:0] out_avg_coarse_dust;
  logic [11:0] out_avg_temperature;
  logic [11:0] out_avg_humidity;

  rx_item_t      rx_bytes [$];
  frame_report_t frame_reports_due [$];
  int            mismatch_count = 0;
  int            stall_left = 0;
  int            idle_run = 0;
  bit            calm = 1'b0;
  string         chan_names [asfm_pkg::CHANNELS] = '{"avg_co2", "avg_formaldehyde", "avg_voc",
                                                     "avg_fine_dust", "avg_coarse_dust",
                                                     "avg_temperature", "avg_humidity"};

  // predictor state
  parse_state_t                        pstate = HUNT_A;
  int                                  fill_idx = 0;
  logic [7:0]                          sum_acc = '0;
  logic [7:0]                          frame_buf [asfm_pkg::DATA_BYTES];
  logic [15:0]                         hist [asfm_pkg::CHANNELS][HISTORY_DEPTH] =
                                         '{default: '0};
  logic [asfm_pkg::CHANNELS-1:0][15:0] chan_avg = '0;
  int                                  stored = 0;

  air_sensor_frame_trimmed_mean_unit #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_status    (out_frame_status),
    .out_avg_co2         (out_avg_co2),
    .out_avg_formaldehyde(out_avg_formaldehyde),
    .out_avg_voc         (out_avg_voc),
    .out_avg_fine_dust   (out_avg_fine_dust),
    .out_avg_coarse_dust (out_avg_coarse_dust),
    .out_avg_temperature (out_avg_temperature),
    .out_avg_humidity    (out_avg_humidity)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // feeds one byte to the parser model; got is set when the byte ends a frame
  task automatic parse_rx_byte(input logic [7:0] b, output bit got, output frame_report_t r);
    logic [asfm_pkg::CHANNELS-1:0][15:0] v;
    logic [31:0]                         total;
    logic [31:0]                         q;
    logic [15:0]                         hi;
    logic [15:0]                         lo;
    got = 1'b0;
    r = '0;
    case (pstate)
      HUNT_A: begin
        if (b == asfm_pkg::HDR_A) pstate = WAIT_B;
      end
      WAIT_B: begin
        if (b == asfm_pkg::HDR_B) begin
          pstate = COLLECT;
          fill_idx = 0;
          sum_acc = asfm_pkg::SUM_SEED;
        end else begin
          pstate = HUNT_A;
        end
      end
      default: begin
        if (fill_idx < asfm_pkg::DATA_BYTES) begin
          frame_buf[fill_idx] = b;
          sum_acc = sum_acc + b;
          fill_idx++;
        end else begin
          for (int c = 0; c < 5; c++) v[c] = {frame_buf[2*c], frame_buf[2*c+1]};
          v[5] = frame_buf[10] * 16'd10 + frame_buf[11];
          v[6] = frame_buf[12] * 16'd10 + frame_buf[13];
          // warm-up test wins over the checksum test
          if (v[0] == 16'd0 && v[1] == 16'd0 && v[2] == 16'd0) begin
            r.status = S_WARM;
          end else if (sum_acc != b) begin
            r.status = S_FAIL;
          end else begin
            for (int c = 0; c < asfm_pkg::CHANNELS; c++) begin
              for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist[c][i] = hist[c][i-1];
              hist[c][0] = v[c];
            end
            if (stored < HISTORY_DEPTH) stored++;
            if (stored < HISTORY_DEPTH) begin
              r.status = S_FILL;
            end else begin
              r.status = S_UPD;
              for (int c = 0; c < asfm_pkg::CHANNELS; c++) begin
                total = '0;
                hi = hist[c][0];
                lo = hist[c][0];
                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                  total = total + hist[c][i];
                  if (hist[c][i] > hi) hi = hist[c][i];
                  if (hist[c][i] < lo) lo = hist[c][i];
                end
                q = (total - hi - lo) / (HISTORY_DEPTH - 2);
                chan_avg[c] = q[15:0];
              end
            end
          end
          r.avg = chan_avg;
          got = 1'b1;
          pstate = HUNT_A;
          fill_idx = 0;
        end
      end
    endcase
  endtask

  task automatic push_plain(logic [7:0] b);
    rx_bytes.push_back(rx_item_t'{b, 1'b0, S_FAIL});
  endtask

  task automatic push_frame(logic [0:13][7:0] d, logic [7:0] skew, logic typed,
                            logic [1:0] st);
    logic [7:0] sum;
    sum = asfm_pkg::SUM_SEED;
    push_plain(asfm_pkg::HDR_A);
    push_plain(asfm_pkg::HDR_B);
    for (int i = 0; i < asfm_pkg::DATA_BYTES; i++) begin
      sum = sum + d[i];
      push_plain(d[i]);
    end
    rx_bytes.push_back(rx_item_t'{sum + skew, typed, st});
  endtask

  // model runs on every accepted byte item
  always @(posedge clk) begin : byte_accept
    bit            got;
    frame_report_t r;
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      parse_rx_byte(in_rx_byte, got, r);
      if (got) begin
        // typed rows come before any average exists
        if (in_typed) begin
          r.status = in_status;
          r.avg = '0;
        end
        frame_reports_due.push_back(r);
      end
    end
  end

  always @(posedge clk) begin : report_check
    frame_report_t                       want;
    logic [asfm_pkg::CHANNELS-1:0][15:0] seen;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen[0] = out_avg_co2;
      seen[1] = out_avg_formaldehyde;
      seen[2] = out_avg_voc;
      seen[3] = out_avg_fine_dust;
      seen[4] = out_avg_coarse_dust;
      seen[5] = {4'h0, out_avg_temperature};
      seen[6] = {4'h0, out_avg_humidity};
      if (frame_reports_due.size() == 0) begin
        report_mismatch("report with none due", 16'(out_frame_status), 16'h0);
      end else begin
        want = frame_reports_due.pop_front();
        if (out_frame_status !== want.status)
          report_mismatch("frame_status", 16'(out_frame_status), 16'(want.status));
        for (int c = 0; c < asfm_pkg::CHANNELS; c++) begin
          if (seen[c] !== want.avg[c]) report_mismatch(chan_names[c], seen[c], want.avg[c]);
        end
      end
    end
  end

  always @(posedge clk) begin : back_pressure
    int n;
    n = stall_left;
    if (n > 0) n = n - 1;
    else if (!calm && $urandom_range(0, 7) == 0) n = $urandom_range(1, 6);
    stall_left <= n;
    out_stall <= (n > 0);
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : run
    rx_item_t         item;
    frame_row_t       row;
    logic [0:13][7:0] d;
    logic [7:0]       skew;
    logic [15:0]      level [5];
    logic [15:0]      w;
    int               pick;
    int               n;

    in_valid <= 1'b0;
    in_rx_byte <= '0;
    in_typed <= 1'b0;
    in_status <= S_FAIL;
    rst_n <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TAB[r];
      for (int i = 0; i < row.lead_n; i++) push_plain(row.lead[i]);
      push_frame(row.data, row.skew, row.typed, row.status);
    end

    for (int c = 0; c < 5; c++) level[c] = 16'($urandom);
    while (rx_bytes.size() < TOTAL_BYTES) begin
      pick = $urandom_range(0, 19);
      for (int i = 0; i < asfm_pkg::DATA_BYTES; i++) d[i] = 8'($urandom);
      n = $urandom_range(0, 3);
      if (n == 0) begin
        // readings clustered around a slowly moving level
        for (int c = 0; c < 5; c++) begin
          if ($urandom_range(0, 15) == 0) level[c] = 16'($urandom);
          w = level[c] + 16'($urandom_range(0, 31));
          d[2*c] = w[15:8];
          d[2*c+1] = w[7:0];
        end
        d[10] = 8'($urandom_range(15, 35));
        d[11] = 8'($urandom_range(0, 9));
        d[12] = 8'($urandom_range(20, 80));
        d[13] = 8'($urandom_range(0, 9));
      end else if (n == 1) begin
        for (int i = 0; i < asfm_pkg::DATA_BYTES; i++)
          d[i] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      if (pick < 13) begin
        push_frame(d, 8'h00, 1'b0, S_FAIL);
      end else if (pick < 15) begin
        for (int i = 0; i < 6; i++) d[i] = 8'h00;
        skew = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
        push_frame(d, skew, 1'b0, S_FAIL);
      end else if (pick < 17) begin
        push_frame(d, 8'($urandom_range(1, 255)), 1'b0, S_FAIL);
      end else if (pick < 19) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          push_plain($urandom_range(0, 2) == 0 ? asfm_pkg::HDR_A : 8'($urandom));
        // a non-header byte brings a parser waiting on the second header byte back to hunting
        push_plain(8'h00);
      end else begin
        // cut-off frame, the next frame's bytes get swallowed
        n = $urandom_range(0, 13);
        push_plain(asfm_pkg::HDR_A);
        push_plain(asfm_pkg::HDR_B);
        for (int i = 0; i < n; i++) push_plain(d[i]);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_bytes.size() != 0) begin
      item = rx_bytes.pop_front();
      calm = (rx_bytes.size() < CALM_TAIL);
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_rx_byte <= item.b;
      in_typed <= item.typed;
      in_status <= item.status;
      @(posedge clk);
      while (in_stall !== 1'b0) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
